// ===== hw/rtl/ray_triangle_intersect_macros.svh =====
// ----------------------------------------------------------------------------
// ray_triangle_intersect_macros
// assertion macros shared by the intersector modules
// ----------------------------------------------------------------------------
`ifndef RAY_TRIANGLE_INTERSECT_MACROS_SVH
`define RAY_TRIANGLE_INTERSECT_MACROS_SVH

// same-cycle implication
`define RTI_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RTI_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/rti_pkg.sv =====
// ----------------------------------------------------------------------------
// rti_pkg
// shared types and constants of the ray / triangle intersector
// ----------------------------------------------------------------------------
package rti_pkg;

  // quotient bits produced by each divider (one per pipeline stage)
  localparam int QUO_BITS = 31;

  // fraction bits of t, u and v
  localparam int FRAC_BITS = 16;

  // queue between classifier and divider back end
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = 2;
  localparam int FIFO_CNT_BITS = 3;

  // classification of one item, carried through queue and dividers
  typedef struct packed {
    logic               reject;
    logic               front;
    logic               tneg;
    logic               tovf;
    logic signed [31:0] dmin;
    logic signed [31:0] dmax;
  } rti_ctl_t;

endpackage

// ===== hw/rtl/rti_fifo.sv =====
// ----------------------------------------------------------------------------
// rti_fifo
// short word queue that decouples the classifier from the dividers
// ----------------------------------------------------------------------------
`include "ray_triangle_intersect_macros.svh"

module rti_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0]                   mem [rti_pkg::FIFO_DEPTH];
  logic [rti_pkg::FIFO_PTR_BITS-1:0]  wptr;
  logic [rti_pkg::FIFO_PTR_BITS-1:0]  rptr;
  logic [rti_pkg::FIFO_CNT_BITS-1:0]  cnt;
  logic                               wr_fire;
  logic                               rd_fire;

  // handshake
  assign wr_ready = (cnt != rti_pkg::FIFO_CNT_BITS'(rti_pkg::FIFO_DEPTH));
  assign rd_valid = (cnt != '0);
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = rd_valid && rd_ready;
  assign rd_data  = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem[wptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (wr_fire) begin
        wptr <= wptr + 1'b1;
      end
      if (rd_fire) begin
        rptr <= rptr + 1'b1;
      end
      if (wr_fire && !rd_fire) begin
        cnt <= cnt + 1'b1;
      end else if (rd_fire && !wr_fire) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  `RTI_ASSERT_NXT(a_cnt_drop, clk, rst, rd_fire && !wr_fire, cnt == $past(cnt) - 1'b1, "queue count did not drop on read")

endmodule

// ===== hw/rtl/rti_div.sv =====
// ----------------------------------------------------------------------------
// rti_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module rti_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 51
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [NUM_W-1:0]             num,
  input  logic [DEN_W-1:0]             den,
  output logic [rti_pkg::QUO_BITS-1:0] quo
);

  localparam int QB = rti_pkg::QUO_BITS;

  logic [DEN_W-1:0] rem_r [QB];
  logic [DEN_W-1:0] den_r [QB];
  logic [QB-1:0]    low_r [QB];
  logic [QB-1:0]    quo_r [QB];

  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic [DEN_W-1:0] r_in;
    logic [DEN_W-1:0] d_in;
    logic [QB-1:0]    l_in;
    logic [QB-1:0]    q_in;
    logic [DEN_W:0]   cand;
    logic             ge;

    // stage inputs: numerator head first, previous stage after
    if (s == 0) begin : g_head
      assign r_in = DEN_W'(num[NUM_W-1:QB]);
      assign d_in = den;
      assign l_in = num[QB-1:0];
      assign q_in = '0;
    end else begin : g_body
      assign r_in = rem_r[s-1];
      assign d_in = den_r[s-1];
      assign l_in = low_r[s-1];
      assign q_in = quo_r[s-1];
    end

    // shift in one numerator bit and try the subtract
    assign cand = {r_in, l_in[QB-1]};
    assign ge   = (cand >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? DEN_W'(cand - {1'b0, d_in}) : DEN_W'(cand);
        den_r[s] <= d_in;
        low_r[s] <= {l_in[QB-2:0], 1'b0};
        quo_r[s] <= {q_in[QB-2:0], ge};
      end
    end
  end

  assign quo = quo_r[QB-1];

endmodule

// ===== hw/rtl/rti_front.sv =====
// ----------------------------------------------------------------------------
// rti_front
// five stage front end: cross and dot products, determinant, classification
// ----------------------------------------------------------------------------
module rti_front #(
  parameter int CB = 16,
  parameter int DW = 3 * CB + 3,
  parameter int NW = 3 * CB + 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [47:0]           ray_origin,
  input  logic [47:0]           ray_direction,
  input  logic [47:0]           vertex_zero,
  input  logic [47:0]           edge_one,
  input  logic [47:0]           edge_two,
  input  logic signed [31:0]    distance_min,
  input  logic signed [31:0]    distance_max,
  input  logic [31:0]           det_epsilon,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rti_pkg::rti_ctl_t     out_ctl,
  output logic [DW-1:0]         out_ad,
  output logic [NW-1:0]         out_mag,
  output logic [DW-1:0]         out_nu,
  output logic [DW-1:0]         out_nv
);

  localparam int SW  = 3 * CB;
  localparam int EW  = (SW > 48) ? SW : 48;
  localparam int TW  = CB + 1;
  localparam int PW  = 2 * CB;
  localparam int QPW = 2 * CB + 1;
  localparam int PVW = 2 * CB + 1;
  localparam int QVW = 2 * CB + 2;
  localparam int CW  = (DW > 32) ? DW : 32;

  logic [4:0] vld;
  logic       en;

  logic [EW-1:0] org_e, dir_e, v0_e, e1_e, e2_e;
  logic signed [CB-1:0] org [3];
  logic signed [CB-1:0] dir [3];
  logic signed [CB-1:0] v0 [3];
  logic signed [CB-1:0] e1 [3];
  logic signed [CB-1:0] e2 [3];
  logic signed [TW-1:0] tv [3];

  logic signed [PW-1:0]  s1_pa [3];
  logic signed [PW-1:0]  s1_pb [3];
  logic signed [QPW-1:0] s1_qa [3];
  logic signed [QPW-1:0] s1_qb [3];
  logic signed [CB-1:0]  s1_dir [3];
  logic signed [CB-1:0]  s1_e1 [3];
  logic signed [CB-1:0]  s1_e2 [3];
  logic signed [TW-1:0]  s1_tv [3];
  logic signed [31:0]    s1_dmin, s1_dmax;

  logic signed [PVW-1:0] s2_pv [3];
  logic signed [QVW-1:0] s2_qv [3];
  logic signed [CB-1:0]  s2_dir [3];
  logic signed [CB-1:0]  s2_e1 [3];
  logic signed [CB-1:0]  s2_e2 [3];
  logic signed [TW-1:0]  s2_tv [3];
  logic signed [31:0]    s2_dmin, s2_dmax;

  logic signed [NW-1:0] s3_dt [3];
  logic signed [NW-1:0] s3_ut [3];
  logic signed [NW-1:0] s3_vt [3];
  logic signed [NW-1:0] s3_tt [3];
  logic signed [31:0]   s3_dmin, s3_dmax;

  logic signed [DW-1:0] s4_det;
  logic signed [NW-1:0] s4_nu, s4_nv, s4_nt;
  logic signed [31:0]   s4_dmin, s4_dmax;

  logic                 neg;
  logic [DW-1:0]        ad_c;
  logic signed [NW-1:0] nun, nvn, ntn;
  logic signed [NW:0]   uv_sum;
  logic [NW-1:0]        mag_c;
  logic                 det_zero, eps_bad, u_bad, v_bad, tovf_c;

  // whole chain advances unless the last stage is held
  assign en        = !vld[4] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[4];

  // unpack components; slot bits above the field read as zero
  assign org_e = EW'(ray_origin);
  assign dir_e = EW'(ray_direction);
  assign v0_e  = EW'(vertex_zero);
  assign e1_e  = EW'(edge_one);
  assign e2_e  = EW'(edge_two);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      org[i] = $signed(org_e[i*CB +: CB]);
      dir[i] = $signed(dir_e[i*CB +: CB]);
      v0[i]  = $signed(v0_e[i*CB +: CB]);
      e1[i]  = $signed(e1_e[i*CB +: CB]);
      e2[i]  = $signed(e2_e[i*CB +: CB]);
      tv[i]  = TW'(org[i]) - TW'(v0[i]);
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  // stage 1: cross product terms of pvec = dir x e2 and qvec = tvec x e1
  always_ff @(posedge clk) begin
    if (en) begin
      s1_pa[0] <= PW'(dir[1]) * PW'(e2[2]);
      s1_pb[0] <= PW'(dir[2]) * PW'(e2[1]);
      s1_pa[1] <= PW'(dir[2]) * PW'(e2[0]);
      s1_pb[1] <= PW'(dir[0]) * PW'(e2[2]);
      s1_pa[2] <= PW'(dir[0]) * PW'(e2[1]);
      s1_pb[2] <= PW'(dir[1]) * PW'(e2[0]);
      s1_qa[0] <= QPW'(tv[1]) * QPW'(e1[2]);
      s1_qb[0] <= QPW'(tv[2]) * QPW'(e1[1]);
      s1_qa[1] <= QPW'(tv[2]) * QPW'(e1[0]);
      s1_qb[1] <= QPW'(tv[0]) * QPW'(e1[2]);
      s1_qa[2] <= QPW'(tv[0]) * QPW'(e1[1]);
      s1_qb[2] <= QPW'(tv[1]) * QPW'(e1[0]);
      s1_dir   <= dir;
      s1_e1    <= e1;
      s1_e2    <= e2;
      s1_tv    <= tv;
      s1_dmin  <= distance_min;
      s1_dmax  <= distance_max;
    end
  end

  // stage 2: cross product differences
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_pv[i] <= PVW'(s1_pa[i]) - PVW'(s1_pb[i]);
        s2_qv[i] <= QVW'(s1_qa[i]) - QVW'(s1_qb[i]);
      end
      s2_dir  <= s1_dir;
      s2_e1   <= s1_e1;
      s2_e2   <= s1_e2;
      s2_tv   <= s1_tv;
      s2_dmin <= s1_dmin;
      s2_dmax <= s1_dmax;
    end
  end

  // stage 3: dot product terms
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s3_dt[i] <= NW'(s2_e1[i]) * NW'(s2_pv[i]);
        s3_ut[i] <= NW'(s2_tv[i]) * NW'(s2_pv[i]);
        s3_vt[i] <= NW'(s2_dir[i]) * NW'(s2_qv[i]);
        s3_tt[i] <= NW'(s2_e2[i]) * NW'(s2_qv[i]);
      end
      s3_dmin <= s2_dmin;
      s3_dmax <= s2_dmax;
    end
  end

  // stage 4: determinant and numerators
  always_ff @(posedge clk) begin
    if (en) begin
      s4_det  <= DW'(s3_dt[0] + s3_dt[1] + s3_dt[2]);
      s4_nu   <= s3_ut[0] + s3_ut[1] + s3_ut[2];
      s4_nv   <= s3_vt[0] + s3_vt[1] + s3_vt[2];
      s4_nt   <= s3_tt[0] + s3_tt[1] + s3_tt[2];
      s4_dmin <= s3_dmin;
      s4_dmax <= s3_dmax;
    end
  end

  // classification: sign fold, epsilon, barycentric bounds, t overflow
  always_comb begin
    neg      = s4_det[DW-1];
    ad_c     = neg ? DW'(~s4_det + 1'b1) : DW'(s4_det);
    nun      = neg ? -s4_nu : s4_nu;
    nvn      = neg ? -s4_nv : s4_nv;
    ntn      = neg ? -s4_nt : s4_nt;
    det_zero = (s4_det == '0);
    eps_bad  = (CW'(ad_c) < CW'(det_epsilon));
    u_bad    = nun[NW-1] || (nun > $signed(NW'(ad_c)));
    uv_sum   = (NW+1)'(nun) + (NW+1)'(nvn);
    v_bad    = nvn[NW-1] || (uv_sum > $signed((NW+1)'(ad_c)));
    mag_c    = ntn[NW-1] ? NW'(-ntn) : NW'(ntn);
    tovf_c   = ((NW+16)'(mag_c) >= ((NW+16)'(ad_c) << 15));
  end

  // stage 5: classified word
  always_ff @(posedge clk) begin
    if (en) begin
      out_ctl.reject <= det_zero || eps_bad || u_bad || v_bad;
      out_ctl.front  <= !neg;
      out_ctl.tneg   <= ntn[NW-1];
      out_ctl.tovf   <= tovf_c;
      out_ctl.dmin   <= s4_dmin;
      out_ctl.dmax   <= s4_dmax;
      out_ad         <= ad_c;
      out_mag        <= mag_c;
      out_nu         <= DW'(nun);
      out_nv         <= DW'(nvn);
    end
  end

endmodule

// ===== hw/rtl/rti_back.sv =====
// ----------------------------------------------------------------------------
// rti_back
// back end: three pipelined dividers, window test and output register
// ----------------------------------------------------------------------------
`include "ray_triangle_intersect_macros.svh"

module rti_back #(
  parameter int DW = 51,
  parameter int NW = 52
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rti_pkg::rti_ctl_t  in_ctl,
  input  logic [DW-1:0]      in_ad,
  input  logic [NW-1:0]      in_mag,
  input  logic [DW-1:0]      in_nu,
  input  logic [DW-1:0]      in_nv,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_hit,
  output logic signed [31:0] out_dist,
  output logic [16:0]        out_u,
  output logic [16:0]        out_v,
  output logic               out_front
);

  localparam int QB = rti_pkg::QUO_BITS;
  localparam int FB = rti_pkg::FRAC_BITS;

  logic                   en;
  logic [QB-1:0]          vld;
  rti_pkg::rti_ctl_t      ctl_p [QB];
  logic [QB-1:0]          quo_t, quo_u, quo_v;
  rti_pkg::rti_ctl_t      c;
  logic signed [31:0]     tq;
  logic                   hit_c;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // dividers for t, u and v
  rti_div #(.NUM_W(NW + FB), .DEN_W(DW)) u_div_t (
    .clk (clk), .en (en), .num ({in_mag, FB'(0)}), .den (in_ad), .quo (quo_t)
  );
  rti_div #(.NUM_W(DW + FB), .DEN_W(DW)) u_div_u (
    .clk (clk), .en (en), .num ({in_nu, FB'(0)}), .den (in_ad), .quo (quo_u)
  );
  rti_div #(.NUM_W(DW + FB), .DEN_W(DW)) u_div_v (
    .clk (clk), .en (en), .num ({in_nv, FB'(0)}), .den (in_ad), .quo (quo_v)
  );

  // valid and classification follow the divider stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QB-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_p[0] <= in_ctl;
      for (int s = 1; s < QB; s++) begin
        ctl_p[s] <= ctl_p[s-1];
      end
    end
  end

  // quantized t with saturation, then window test
  always_comb begin
    c = ctl_p[QB-1];
    if (c.tovf) begin
      tq = c.tneg ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      tq = c.tneg ? $signed(32'd0 - {1'b0, quo_t}) : $signed({1'b0, quo_t});
    end
    hit_c = !c.reject && (tq >= c.dmin) && (tq <= c.dmax);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit   <= hit_c;
      out_dist  <= hit_c ? tq : '0;
      out_u     <= hit_c ? quo_u[16:0] : '0;
      out_v     <= hit_c ? quo_v[16:0] : '0;
      out_front <= hit_c && c.front;
    end
  end

  `RTI_ASSERT_NXT(a_pipe_adv, clk, rst, en && vld[QB-1], out_valid, "divider result lost on the way out")
  `RTI_ASSERT_IMP(a_miss_zero, clk, rst, out_valid && !out_hit, out_dist == '0 && out_u == '0 && out_v == '0 && !out_front, "miss word not cleared")
  `RTI_ASSERT_IMP(a_bary_range, clk, rst, out_valid, (18'(out_u) + 18'(out_v)) <= 18'h10000, "barycentric weights out of range")

endmodule

// ===== hw/rtl/ray_triangle_intersect.sv =====
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// moller-trumbore ray / triangle intersection, streaming, fixed point
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  s_*     | in  | tdata: origin, direction, vertex_zero, edge_one, edge_two,
//          |     |        distance_min, distance_max
//  m_*     | out | tuser: hit; tdata: hit_distance, bary_u, bary_v, facing
//  cfg_*   | in  | det_epsilon write
//
//  one word per cycle while the output is not held; a word passes 38 registers
//  (five classifier stages, one queue write, 31 divider stages of one
//  quotient bit each and the output register).
//  rst is synchronous; it empties the pipelines and queue and sets
//  det_epsilon to 1.
//  a held output stalls the dividers; the four-word queue lets the front end
//  keep accepting until it fills.
// ----------------------------------------------------------------------------
module ray_triangle_intersect #(
  parameter int COORD_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // ray_origin[47:0], ray_direction[95:48], vertex_zero[143:96],
  // edge_one[191:144], edge_two[239:192], distance_min[271:240],
  // distance_max[303:272]
  input  logic [303:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // hit_distance[31:0], bary_u[48:32], bary_v[65:49], facing[66], zero pad
  output logic [71:0]  m_tdata,
  // hit[0]
  output logic [0:0]   m_tuser
);

  localparam int DW  = 3 * COORD_BITS + 3;
  localparam int NW  = 3 * COORD_BITS + 4;
  localparam int CTW = $bits(rti_pkg::rti_ctl_t);
  localparam int QW  = CTW + 3 * DW + NW;

  logic [31:0]        det_epsilon;
  logic               f_valid, f_ready;
  rti_pkg::rti_ctl_t  f_ctl;
  logic [DW-1:0]      f_ad, f_nu, f_nv;
  logic [NW-1:0]      f_mag;
  logic               b_valid, b_ready;
  logic [QW-1:0]      b_word;
  logic               o_hit, o_front;
  logic signed [31:0] o_dist;
  logic [16:0]        o_u, o_v;

  // epsilon register
  always_ff @(posedge clk) begin
    if (rst) begin
      det_epsilon <= 32'd1;
    end else if (cfg_wr_en) begin
      det_epsilon <= cfg_wr_data;
    end
  end

  // classifier
  rti_front #(.CB(COORD_BITS), .DW(DW), .NW(NW)) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .ray_origin    (s_tdata[47:0]),
    .ray_direction (s_tdata[95:48]),
    .vertex_zero   (s_tdata[143:96]),
    .edge_one      (s_tdata[191:144]),
    .edge_two      (s_tdata[239:192]),
    .distance_min  (s_tdata[271:240]),
    .distance_max  (s_tdata[303:272]),
    .det_epsilon   (det_epsilon),
    .out_valid     (f_valid),
    .out_ready     (f_ready),
    .out_ctl       (f_ctl),
    .out_ad        (f_ad),
    .out_mag       (f_mag),
    .out_nu        (f_nu),
    .out_nv        (f_nv)
  );

  // queue between classifier and dividers
  rti_fifo #(.WIDTH(QW)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  ({f_ctl, f_ad, f_mag, f_nu, f_nv}),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_word)
  );

  // dividers and output stage
  rti_back #(.DW(DW), .NW(NW)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b_valid),
    .in_ready  (b_ready),
    .in_ctl    (b_word[QW-1 -: CTW]),
    .in_ad     (b_word[2*DW+NW +: DW]),
    .in_mag    (b_word[2*DW +: NW]),
    .in_nu     (b_word[DW +: DW]),
    .in_nv     (b_word[0 +: DW]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_hit   (o_hit),
    .out_dist  (o_dist),
    .out_u     (o_u),
    .out_v     (o_v),
    .out_front (o_front)
  );

  // output packing
  assign m_tdata = {5'd0, o_front, o_v, o_u, o_dist};
  assign m_tuser = o_hit;

endmodule
